// ===== rtl/sfd_pkg.sv =====
// Shared types and constants for the serial frame deframer.
// Used by the configuration registers, the parser, the top level and the checker.
package sfd_pkg;

  localparam int ByteW  = 8;
  localparam int PosW   = 7;
  localparam int EntryW = 16;
  localparam int IndexW = 3;

  // Configuration register indexes.
  localparam logic [IndexW-1:0] REG_HEADER_FIRST  = 3'd0;
  localparam logic [IndexW-1:0] REG_HEADER_SECOND = 3'd1;
  localparam logic [IndexW-1:0] REG_TAIL_VALUE    = 3'd2;
  localparam logic [IndexW-1:0] REG_LENGTH_FIRST  = 3'd3;

  typedef enum logic [1:0] {
    PH_WAIT_FIRST,
    PH_WAIT_SECOND,
    PH_WAIT_TYPE,
    PH_DATA
  } phase_t;

  typedef enum logic [2:0] {
    ST_DROP,
    ST_IN_FRAME,
    ST_GOOD,
    ST_BAD_SUM,
    ST_ABORT
  } status_t;

  typedef struct packed {
    logic [ByteW-1:0] header_first;
    logic [ByteW-1:0] header_second;
    logic [ByteW-1:0] tail_value;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] byte_echo;
    logic [PosW-1:0]  position;
    status_t          status;
  } result_t;

endpackage

// ===== rtl/sfd_cfg_regs.sv =====
// Configuration register file of the serial frame deframer: headers, tail and
// the type-to-length entries. Depends on sfd_pkg.
module sfd_cfg_regs import sfd_pkg::*; #(
  parameter int LENGTH_ENTRIES = 4
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [IndexW-1:0]                      cfg_index,
  input  logic [EntryW-1:0]                      cfg_data,
  output cfg_t                                   cfg,
  output logic [LENGTH_ENTRIES-1:0][EntryW-1:0]  length_entry
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_HEADER_FIRST) begin
        cfg.header_first <= cfg_data[ByteW-1:0];
      end
      if (cfg_index == REG_HEADER_SECOND) begin
        cfg.header_second <= cfg_data[ByteW-1:0];
      end
      if (cfg_index == REG_TAIL_VALUE) begin
        cfg.tail_value <= cfg_data[ByteW-1:0];
      end
    end
  end

  // Writes to entries beyond LENGTH_ENTRIES are accepted and discarded.
  for (genvar k = 0; k < LENGTH_ENTRIES; k++) begin : g_entry
    always_ff @(posedge clk) begin
      if (rst) begin
        length_entry[k] <= '0;
      end else if (cfg_we && cfg_index == IndexW'(int'(REG_LENGTH_FIRST) + k)) begin
        length_entry[k] <= cfg_data;
      end
    end
  end

endmodule

// ===== rtl/sfd_parser.sv =====
// Frame parser state machine: tracks phase, count, expected length and the
// lagged checksum, and classifies each byte. Depends on sfd_pkg.
module sfd_parser import sfd_pkg::*; #(
  parameter int MAX_FRAME      = 100,
  parameter int LENGTH_ENTRIES = 4
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   advance,
  input  logic [ByteW-1:0]                       rx_byte,
  input  cfg_t                                   cfg,
  input  logic [LENGTH_ENTRIES-1:0][EntryW-1:0]  length_entry,
  output result_t                                result
);

  localparam logic [PosW-1:0] MaxCount = PosW'(MAX_FRAME);

  phase_t           phase, phase_next;
  logic [PosW-1:0]  byte_count, byte_count_next;
  logic [ByteW-1:0] expected_length, expected_length_next;
  logic [ByteW-1:0] lagged_sum, lagged_sum_next;
  logic [ByteW-1:0] previous_byte, previous_byte_next;

  logic [PosW-1:0]  count_inc;
  logic             tail_hit;
  logic             at_max;
  logic [ByteW-1:0] looked_up;

  assign count_inc = byte_count + PosW'(1);
  assign tail_hit  = (rx_byte == cfg.tail_value) &&
                     ({1'b0, count_inc} == expected_length);
  assign at_max    = (count_inc >= MaxCount);

  // Walk from the top entry down so the lowest matching index wins.
  always_comb begin
    looked_up = '0;
    for (int k = LENGTH_ENTRIES - 1; k >= 0; k--) begin
      if (length_entry[k][EntryW-1:ByteW] == rx_byte) begin
        looked_up = length_entry[k][ByteW-1:0];
      end
    end
  end

  always_comb begin
    phase_next           = phase;
    byte_count_next      = byte_count;
    expected_length_next = expected_length;
    lagged_sum_next      = lagged_sum;
    previous_byte_next   = previous_byte;
    unique case (phase)
      PH_WAIT_FIRST: begin
        if (rx_byte == cfg.header_first) begin
          phase_next      = PH_WAIT_SECOND;
          byte_count_next = PosW'(1);
        end else begin
          byte_count_next = '0;
        end
      end
      PH_WAIT_SECOND: begin
        if (rx_byte == cfg.header_second) begin
          phase_next      = PH_WAIT_TYPE;
          byte_count_next = PosW'(2);
        end else begin
          phase_next      = PH_WAIT_FIRST;
          byte_count_next = '0;
        end
      end
      PH_WAIT_TYPE: begin
        phase_next           = PH_DATA;
        byte_count_next      = PosW'(3);
        expected_length_next = looked_up;
        lagged_sum_next      = '0;
        previous_byte_next   = rx_byte;
      end
      PH_DATA: begin
        if (tail_hit || at_max) begin
          phase_next      = PH_WAIT_FIRST;
          byte_count_next = '0;
        end else begin
          byte_count_next    = count_inc;
          lagged_sum_next    = lagged_sum + previous_byte;
          previous_byte_next = rx_byte;
        end
      end
    endcase
  end

  always_comb begin
    result.byte_echo = rx_byte;
    result.position  = '0;
    result.status    = ST_DROP;
    unique case (phase)
      PH_WAIT_FIRST: begin
        if (rx_byte == cfg.header_first) begin
          result.position = PosW'(1);
          result.status   = ST_IN_FRAME;
        end
      end
      PH_WAIT_SECOND: begin
        if (rx_byte == cfg.header_second) begin
          result.position = PosW'(2);
          result.status   = ST_IN_FRAME;
        end
      end
      PH_WAIT_TYPE: begin
        result.position = PosW'(3);
        result.status   = ST_IN_FRAME;
      end
      PH_DATA: begin
        result.position = count_inc;
        // A completed frame takes precedence over the length limit.
        priority if (tail_hit) begin
          result.status = (lagged_sum == previous_byte) ? ST_GOOD : ST_BAD_SUM;
        end else if (at_max) begin
          result.status = ST_ABORT;
        end else begin
          result.status = ST_IN_FRAME;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_WAIT_FIRST;
      byte_count      <= '0;
      expected_length <= '0;
      lagged_sum      <= '0;
      previous_byte   <= '0;
    end else if (advance) begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      expected_length <= expected_length_next;
      lagged_sum      <= lagged_sum_next;
      previous_byte   <= previous_byte_next;
    end
  end

endmodule

// ===== rtl/serial_frame_deframer.sv =====
// Serial frame deframer top level: input register, frame parser and result register.
// An accepted beat passes from the input register through the parser to the result register.
// Throughput: one byte per cycle unless out_ready stalls, set by the single-pass parser.
// While a result waits to be taken, the input register can take one more beat.
// Reset (rst, synchronous) empties both registers, returns the parser to
// waiting for a first header and clears all configuration registers to zero.
module serial_frame_deframer import sfd_pkg::*; #(
  parameter int MAX_FRAME      = 100,
  parameter int LENGTH_ENTRIES = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IndexW-1:0] cfg_index,
  input  logic [EntryW-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ByteW-1:0]  rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ByteW-1:0]  byte_echo,
  output logic [PosW-1:0]   frame_position,
  output logic [2:0]        parse_status
);

  cfg_t                                  cfg;
  logic [LENGTH_ENTRIES-1:0][EntryW-1:0] length_entry;

  logic             s1_valid;
  logic [ByteW-1:0] s1_byte;
  logic             out_load;
  result_t          parsed;
  result_t          out_reg;

  sfd_cfg_regs #(
    .LENGTH_ENTRIES(LENGTH_ENTRIES)
  ) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg),
    .length_entry (length_entry)
  );

  assign out_load = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= rx_byte;
    end
  end

  sfd_parser #(
    .MAX_FRAME      (MAX_FRAME),
    .LENGTH_ENTRIES (LENGTH_ENTRIES)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .advance      (out_load),
    .rx_byte      (s1_byte),
    .cfg          (cfg),
    .length_entry (length_entry),
    .result       (parsed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_reg <= parsed;
    end
  end

  assign byte_echo      = out_reg.byte_echo;
  assign frame_position = out_reg.position;
  assign parse_status   = out_reg.status;

endmodule

// ===== rtl/sfd_checker.sv =====
// Port-level checker for the serial frame deframer, bound to the top level.
// Depends on sfd_pkg.
module sfd_checker import sfd_pkg::*; #(
  parameter int MAX_FRAME = 100
) (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ByteW-1:0]  byte_echo,
  input logic [PosW-1:0]   frame_position,
  input logic [2:0]        parse_status
);

  localparam logic [PosW-1:0] MaxCount = PosW'(MAX_FRAME);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(byte_echo) &&
      $stable(frame_position) && $stable(parse_status))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_drop_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && parse_status == ST_DROP |-> frame_position == '0)
    else $error("dropped byte with nonzero position");

  a_abort_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && parse_status == ST_ABORT |-> frame_position == MaxCount)
    else $error("abort reported away from the maximum length");

  a_in_frame_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && parse_status == ST_IN_FRAME |->
      frame_position != '0 && frame_position < MaxCount)
    else $error("in-frame position out of range");

endmodule

bind serial_frame_deframer sfd_checker #(.MAX_FRAME(MAX_FRAME)) u_sfd_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .byte_echo      (byte_echo),
  .frame_position (frame_position),
  .parse_status   (parse_status)
);

// ===== bench/tb_serial_frame_deframer.sv =====
// Testbench for the serial frame deframer: directed and random byte streams with checking.
// A tracker class mirrors the frame parser and checks each result beat in order.
// Depends on sfd_pkg and serial_frame_deframer.
module tb_serial_frame_deframer;
  timeunit 1ns;
  timeprecision 1ps;
  import sfd_pkg::*;

  localparam int FrameLimit    = 100;
  localparam int LengthEntries = 4;
  localparam int NumPhases     = 8;
  localparam int PhaseBytes    = 70;
  localparam int SettleCycles  = 4;
  localparam int StuckLimit    = 2000;
  // Index past the last length entry; writes to it must have no effect.
  localparam logic [IndexW-1:0] REG_SPARE = 3'd7;

  class frame_tracker;
    logic [ByteW-1:0]  hdr_first;
    logic [ByteW-1:0]  hdr_second;
    logic [ByteW-1:0]  tail_byte;
    logic [EntryW-1:0] length_entry [LengthEntries];
    phase_t            phase;
    logic [PosW-1:0]   count;
    logic [ByteW-1:0]  want_len;
    logic [ByteW-1:0]  running_sum;
    logic [ByteW-1:0]  held_byte;
    result_t           pending_reports [$];
    int                errors;

    function new();
      hdr_first   = '0;
      hdr_second  = '0;
      tail_byte   = '0;
      foreach (length_entry[k]) length_entry[k] = '0;
      phase       = PH_WAIT_FIRST;
      count       = '0;
      want_len    = '0;
      running_sum = '0;
      held_byte   = '0;
      errors      = 0;
    endfunction

    function void write_reg(logic [IndexW-1:0] idx, logic [EntryW-1:0] value);
      if (idx == REG_HEADER_FIRST) hdr_first = value[ByteW-1:0];
      else if (idx == REG_HEADER_SECOND) hdr_second = value[ByteW-1:0];
      else if (idx == REG_TAIL_VALUE) tail_byte = value[ByteW-1:0];
      else if (idx >= REG_LENGTH_FIRST && idx < REG_LENGTH_FIRST + LengthEntries)
        length_entry[idx - REG_LENGTH_FIRST] = value;
    endfunction

    // The lowest-indexed entry wins when type codes repeat; no match means length zero.
    function logic [ByteW-1:0] length_of(logic [ByteW-1:0] kind);
      for (int k = 0; k < LengthEntries; k++) begin
        if (length_entry[k][EntryW-1:ByteW] == kind) return length_entry[k][ByteW-1:0];
      end
      return '0;
    endfunction

    function void parse_byte(logic [ByteW-1:0] value);
      result_t r;
      r.byte_echo = value;
      r.position  = '0;
      r.status    = ST_DROP;
      if (phase == PH_WAIT_FIRST && value == hdr_first) begin
        phase      = PH_WAIT_SECOND;
        count      = 7'd1;
        r.position = count;
        r.status   = ST_IN_FRAME;
      end else if (phase == PH_WAIT_SECOND && value == hdr_second) begin
        phase      = PH_WAIT_TYPE;
        count      = 7'd2;
        r.position = count;
        r.status   = ST_IN_FRAME;
      end else if (phase == PH_WAIT_TYPE) begin
        phase       = PH_DATA;
        count       = 7'd3;
        want_len    = length_of(value);
        running_sum = '0;
        held_byte   = value;
        r.position  = count;
        r.status    = ST_IN_FRAME;
      end else if (phase == PH_DATA) begin
        count      = count + 1'b1;
        r.position = count;
        // The checksum verdict wins over the abort when both land on the same byte.
        if (value == tail_byte && {1'b0, count} == want_len) begin
          r.status = (running_sum == held_byte) ? ST_GOOD : ST_BAD_SUM;
          phase    = PH_WAIT_FIRST;
          count    = '0;
        end else if (count >= FrameLimit) begin
          r.status = ST_ABORT;
          phase    = PH_WAIT_FIRST;
          count    = '0;
        end else begin
          r.status    = ST_IN_FRAME;
          running_sum = running_sum + held_byte;
          held_byte   = value;
        end
      end else begin
        phase = PH_WAIT_FIRST;
        count = '0;
      end
      pending_reports.push_back(r);
    endfunction

    function void compare_report(logic [ByteW-1:0] echo, logic [PosW-1:0] pos,
                                 logic [2:0] status);
      result_t want;
      if (pending_reports.size() == 0) begin
        $error("result beat with nothing pending: byte_echo %0h", echo);
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      if (echo !== want.byte_echo) begin
        $error("byte_echo: expected %0h, actual %0h", want.byte_echo, echo);
        errors++;
      end
      if (pos !== want.position) begin
        $error("frame_position: expected %0d, actual %0d", want.position, pos);
        errors++;
      end
      if (status !== want.status) begin
        $error("parse_status: expected %0d, actual %0d", want.status, status);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [IndexW-1:0] cfg_index;
  logic [EntryW-1:0] cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic [ByteW-1:0]  rx_byte;
  logic              out_valid;
  logic              out_ready;
  logic [ByteW-1:0]  byte_echo;
  logic [PosW-1:0]   frame_position;
  logic [2:0]        parse_status;

  frame_tracker tracker = new();
  int gap_pct      = 0;
  int stall_pct    = 0;
  int sent_bytes   = 0;
  int stuck_cycles = 0;

  serial_frame_deframer #(
    .MAX_FRAME(FrameLimit),
    .LENGTH_ENTRIES(LengthEntries)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .byte_echo(byte_echo),
    .frame_position(frame_position),
    .parse_status(parse_status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready = ($urandom_range(99, 0) >= stall_pct);
  end

  // Beats are taken at the rising edge, before the block's own updates land.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) tracker.parse_byte(rx_byte);
      if (out_valid && out_ready)
        tracker.compare_report(byte_echo, frame_position, parse_status);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= StuckLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] value);
    while ($urandom_range(99, 0) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    rx_byte  = value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
    sent_bytes++;
  endtask

  task automatic write_reg(input logic [IndexW-1:0] idx, input logic [EntryW-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.write_reg(idx, value);
  endtask

  // Holds the sender back until every pending result has come out.
  task automatic drain();
    while (tracker.pending_reports.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Upper bits of the byte-wide registers get random values; the block must ignore them.
  task automatic load_settings(input logic [ByteW-1:0] first, input logic [ByteW-1:0] second,
                               input logic [ByteW-1:0] tail, input logic [EntryW-1:0] ent_a,
                               input logic [EntryW-1:0] ent_b, input logic [EntryW-1:0] ent_c,
                               input logic [EntryW-1:0] ent_d);
    write_reg(REG_HEADER_FIRST, {8'($urandom_range(255, 0)), first});
    write_reg(REG_HEADER_SECOND, {8'($urandom_range(255, 0)), second});
    write_reg(REG_TAIL_VALUE, {8'($urandom_range(255, 0)), tail});
    write_reg(REG_LENGTH_FIRST, ent_a);
    write_reg(REG_LENGTH_FIRST + 3'd1, ent_b);
    write_reg(REG_LENGTH_FIRST + 3'd2, ent_c);
    write_reg(REG_LENGTH_FIRST + 3'd3, ent_d);
    write_reg(REG_SPARE, 16'($urandom_range(65535, 0)));
  endtask

  // Frames whose length can never complete are followed by enough bytes to hit the abort.
  task automatic send_frame(input logic [ByteW-1:0] kind, input bit bad_sum, input bit bad_tail);
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] value;
    int               len;
    len = tracker.length_of(kind);
    sum = kind;
    send_byte(tracker.hdr_first);
    send_byte(tracker.hdr_second);
    send_byte(kind);
    if (len < 4 || len > FrameLimit) begin
      repeat (FrameLimit - 3) send_byte(8'($urandom_range(255, 0)));
    end else begin
      for (int k = 4; k <= len - 2; k++) begin
        value = $urandom_range(255, 0);
        sum   = sum + value;
        send_byte(value);
      end
      if (len >= 5) send_byte(bad_sum ? sum ^ 8'($urandom_range(255, 1)) : sum);
      send_byte(bad_tail ? tracker.tail_byte ^ 8'($urandom_range(255, 1)) : tracker.tail_byte);
    end
  endtask

  function automatic logic [ByteW-1:0] random_length();
    int roll;
    roll = $urandom_range(99, 0);
    if (roll < 80) return 8'($urandom_range(12, 4));
    if (roll < 88) return 8'($urandom_range(40, 13));
    if (roll < 92) return 8'(FrameLimit);
    if (roll < 96) return 8'($urandom_range(3, 0));
    return 8'($urandom_range(255, FrameLimit + 1));
  endfunction

  function automatic logic [EntryW-1:0] random_entry();
    return {8'($urandom_range(255, 0)), random_length()};
  endfunction

  initial begin
    logic [ByteW-1:0] opening [25];
    logic [ByteW-1:0] kind;
    int               roll;
    int               phase_end;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    rx_byte   = '0;
    out_ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Type 0 has length four, type 1 is listed twice (length 8 wins), type 2 fills a
    // whole frame so that its tail lands exactly on the maximum.
    load_settings(8'hAA, 8'h55, 8'h0D, 16'h0004, 16'h0108, 16'h0106, 16'h0264);
    opening = '{8'h00, 8'hFF,
                8'hAA, 8'hAA, 8'h55,
                8'hAA, 8'h55, 8'h00, 8'h0D,
                8'hAA, 8'h55, 8'h01, 8'hFF, 8'h00, 8'h80, 8'h80, 8'h0D,
                8'hAA, 8'h55, 8'h01, 8'h10, 8'h20, 8'h30, 8'h00, 8'h0D};
    foreach (opening[k]) send_byte(opening[k]);
    send_frame(8'h02, 1'b0, 1'b0);
    send_frame(8'h77, 1'b0, 1'b0);

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      case (p)
        0: ;
        1: load_settings(8'h00, 8'h00, 8'h00, 16'h0000, random_entry(), random_entry(),
                         16'hFFFF);
        2: load_settings(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, random_entry(), random_entry(),
                         {8'($urandom_range(255, 0)), 8'(FrameLimit)});
        default: load_settings(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                               8'($urandom_range(255, 0)), random_entry(), random_entry(),
                               random_entry(), random_entry());
      endcase
      case (p % 4)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 62;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 62;
        end
        default: begin
          gap_pct   = 17;
          stall_pct = 17;
        end
      endcase
      phase_end = sent_bytes + PhaseBytes;
      while (sent_bytes < phase_end) begin
        roll = $urandom_range(99, 0);
        kind = tracker.length_entry[$urandom_range(LengthEntries - 1, 0)][EntryW-1:ByteW];
        if (roll < 3) drain();
        if (roll < 68) send_frame(kind, 1'b0, 1'b0);
        else if (roll < 78) send_frame(kind, 1'b1, 1'b0);
        else if (roll < 83) send_frame(kind, 1'b0, 1'b1);
        else if (roll < 93) repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255, 0)));
        else if (roll < 97) begin
          send_byte(tracker.hdr_first);
          send_byte(8'($urandom_range(255, 0)));
        end else send_frame(8'($urandom_range(255, 0)), 1'b0, 1'b0);
      end
    end

    drain();
    if (tracker.errors == 0 && tracker.pending_reports.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
